### rtl/rgb2hsv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared widths and default fixed-point settings for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

	localparam int PIX_W = 8;
	localparam int HUE_W = 13;
	localparam int SAT_W = 13;

	localparam int HUE_FRACTION_BITS_DEF = 4;
	localparam int SAT_FRACTION_BITS_DEF = 12;

	// a tee of six 60 degree sectors, in whole degrees
	localparam int DEG_PER_SECTOR = 60;

endpackage

### rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined conversion of one 8-bit RGB pixel per clock into hue, saturation
// and value unless stalled, with both divisions done one quotient bit per stage.
// ----------------------------------------------------------------------------
// usage
//   pixel channel: red, green, blue with pixel_valid / pixel_ready
//   hsv channel: hue, saturation, brightness with hsv_valid / hsv_ready
//   a beat is taken on each channel when its valid and ready are both high
//   hue is in 1/2^HUE_FRACTION_BITS degree, saturation in 1/2^SAT_FRACTION_BITS
//   from the input beat to hsv_valid a pixel passes the front-end register, the
//   dividend register, the NDIV divider stages and the output register, where
//   NDIV = max(9 + HUE_FRACTION_BITS, SAT_FRACTION_BITS + 1)
//   throughput is one pixel per cycle while hsv_ready does not stall the output;
//   the restoring divider chain of NDIV stages retires one quotient bit of hue
//   and of saturation each every stage
//   each stage holds its beat until the next one is free, so a stall at the
//   output fills the empty stages first and drops or repeats nothing
//   reset empties the pipeline; no beat is in flight afterwards
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
	import rgb2hsv_pkg::*;
#(
	parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF,
	parameter int SAT_FRACTION_BITS = SAT_FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	output logic             hsv_valid,
	input  logic             hsv_ready,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] saturation,
	output logic [PIX_W-1:0] brightness
);

	localparam int HQ_W = 9 + HUE_FRACTION_BITS;
	localparam int SQ_W = SAT_FRACTION_BITS + 1;
	localparam int NDIV = (HQ_W > SQ_W) ? HQ_W : SQ_W;
	localparam int DW   = NDIV + PIX_W;
	localparam int T_W  = PIX_W + 3;
	localparam int SC   = DEG_PER_SECTOR << HUE_FRACTION_BITS;

	typedef struct packed {
		logic [PIX_W-1:0] hrem;
		logic [NDIV-1:0]  hqd;
		logic [PIX_W-1:0] hdiv;
		logic [PIX_W-1:0] srem;
		logic [NDIV-1:0]  sqd;
		logic [PIX_W-1:0] sdiv;
		logic             hue_zero;
		logic             sat_zero;
		logic [PIX_W-1:0] bright;
	} div_stage_t;

	// front end
	logic             red_max, green_max;
	logic [PIX_W-1:0] mx, mn, dd;
	logic [T_W-1:0]   tt;

	logic             v_s1;
	logic [T_W-1:0]   t_s1;
	logic [PIX_W-1:0] d_s1, mx_s1;
	logic             adv_s1;

	div_stage_t       ds_s   [0:NDIV];
	logic             dv_s   [0:NDIV];
	logic             dadv   [0:NDIV];

	logic [DW-1:0]    hnum, snum;

	logic             valid_q;
	logic             out_adv;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [PIX_W-1:0] bright_q;

	// handshake chain, each stage moves when it is empty or its successor moves
	assign out_adv      = !valid_q || hsv_ready;
	assign dadv[NDIV]   = !dv_s[NDIV] || out_adv;

	for (genvar k = 0; k < NDIV; k++) begin : g_adv
		assign dadv[k] = !dv_s[k] || dadv[k+1];
	end

	assign adv_s1      = !v_s1 || dadv[0];
	assign pixel_ready = adv_s1;

	// max, min and the sector numerator
	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		mx = red_max ? red : (green_max ? green : blue);
		if ((red <= green) && (red <= blue)) begin
			mn = red;
		end else if (green <= blue) begin
			mn = green;
		end else begin
			mn = blue;
		end
		dd = mx - mn;
		if (red_max) begin
			if (green >= blue) begin
				tt = T_W'(green) - T_W'(blue);
			end else begin
				tt = T_W'({dd, 2'b00}) + T_W'({dd, 1'b0}) + T_W'(green) - T_W'(blue);
			end
		end else if (green_max) begin
			tt = T_W'({dd, 1'b0}) + T_W'(blue) - T_W'(red);
		end else begin
			tt = T_W'({dd, 2'b00}) + T_W'(red) - T_W'(green);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			t_s1  <= tt;
			d_s1  <= dd;
			mx_s1 <= mx;
		end
	end

	// scaled dividends
	assign hnum = DW'(t_s1) * DW'(SC);
	assign snum = DW'(d_s1) << SAT_FRACTION_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (dadv[0]) begin
			dv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dadv[0]) begin
			ds_s[0].hrem     <= hnum[DW-1:NDIV];
			ds_s[0].hqd      <= hnum[NDIV-1:0];
			ds_s[0].hdiv     <= d_s1;
			ds_s[0].srem     <= snum[DW-1:NDIV];
			ds_s[0].sqd      <= snum[NDIV-1:0];
			ds_s[0].sdiv     <= mx_s1;
			ds_s[0].hue_zero <= (d_s1 == '0);
			ds_s[0].sat_zero <= (mx_s1 == '0);
			ds_s[0].bright   <= mx_s1;
		end
	end

	// restoring division, one quotient bit of each result per stage
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [PIX_W:0] hx, sx;
		logic           hge, sge;

		assign hx  = {ds_s[k].hrem, ds_s[k].hqd[NDIV-1]};
		assign sx  = {ds_s[k].srem, ds_s[k].sqd[NDIV-1]};
		assign hge = hx >= {1'b0, ds_s[k].hdiv};
		assign sge = sx >= {1'b0, ds_s[k].sdiv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (dadv[k+1]) begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (dadv[k+1]) begin
				ds_s[k+1].hrem     <= hge ? PIX_W'(hx - {1'b0, ds_s[k].hdiv}) : hx[PIX_W-1:0];
				ds_s[k+1].hqd      <= {ds_s[k].hqd[NDIV-2:0], hge};
				ds_s[k+1].hdiv     <= ds_s[k].hdiv;
				ds_s[k+1].srem     <= sge ? PIX_W'(sx - {1'b0, ds_s[k].sdiv}) : sx[PIX_W-1:0];
				ds_s[k+1].sqd      <= {ds_s[k].sqd[NDIV-2:0], sge};
				ds_s[k+1].sdiv     <= ds_s[k].sdiv;
				ds_s[k+1].hue_zero <= ds_s[k].hue_zero;
				ds_s[k+1].sat_zero <= ds_s[k].sat_zero;
				ds_s[k+1].bright   <= ds_s[k].bright;
			end
		end
	end

	// output register, hue forced to zero for grey pixels and saturation for black ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_adv) begin
			valid_q <= dv_s[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			hue_q    <= ds_s[NDIV].hue_zero ? '0 : HUE_W'(ds_s[NDIV].hqd);
			sat_q    <= ds_s[NDIV].sat_zero ? '0 : SAT_W'(ds_s[NDIV].sqd);
			bright_q <= ds_s[NDIV].bright;
		end
	end

	assign hsv_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule
